// ----- src/bme_pkg.sv -----
// Shared types and constants for the binary morphology engine.
// Used by every module of the block but the image memory; depends on nothing else.
`default_nettype none

package bme_pkg;

    // Default image memory size and fixed field widths.
    localparam int MaxWidthDef  = 256;
    localparam int MaxHeightDef = 256;
    localparam int MaxElement   = 7;
    localparam int MaskStride   = 7;
    localparam int MaskW        = 49;
    localparam int SizeW        = 9;
    localparam int ElemW        = 3;
    localparam int PixW         = 8;
    localparam int CoordW       = 10;
    localparam int CfgIdxW      = 3;
    localparam int SizeMax      = 511;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgMode     = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgImgW     = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgImgH     = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgElemW    = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgElemH    = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgElemMask = 3'd5;

    // Operation and mode codes.
    localparam logic OpLoad     = 1'b0;
    localparam logic OpQuery    = 1'b1;
    localparam logic ModeDilate = 1'b0;
    localparam logic ModeErode  = 1'b1;

    // Pixel constants.
    localparam logic [PixW-1:0] GreyThreshold = 8'd128;
    localparam logic [PixW-1:0] White         = 8'd255;
    localparam logic [PixW-1:0] Black         = 8'd0;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        logic            opcode;
        logic [PixW-1:0] row;
        logic [PixW-1:0] col;
        logic [PixW-1:0] grey;
    } t_in_item;

    typedef struct packed {
        logic [PixW-1:0] out_row;
        logic [PixW-1:0] out_col;
        logic [PixW-1:0] out_value;
        logic            out_of_range;
    } t_out_item;

    // Effective configuration, already clamped to the memory size.
    typedef struct packed {
        logic             mode;
        logic [SizeW-1:0] img_w;
        logic [SizeW-1:0] img_h;
        logic [ElemW-1:0] elem_w;
        logic [ElemW-1:0] elem_h;
        logic [MaskW-1:0] mask;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_WR,
        S_ISSUE,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- src/binary_morphology_engine_top.sv -----
// Top level of the binary morphology engine: configuration registers,
// row-wide image memory and query sequencer. Depends on bme_pkg.
`default_nettype none

// Pixels are loaded one per transfer and binarized (grey of 128 or more
// stores 1) into an image memory holding one word per image row. A load
// is a row read followed by the write-back of the modified row; a load
// outside the image is dropped. A query in range reads one image row per
// element row through the single read port of the image memory; a query
// outside the image or with an element height of zero reads no row.
// Results wait in an output register, so a new item can be taken while a
// result is still stalled. Loaded pixels are not cleared by reset and must
// be written before a query reads them; configuration must be written only
// while no item is in flight, which the block itself does not enforce.
module binary_morphology_engine_top #(
    parameter int MaxWidth  = bme_pkg::MaxWidthDef,
    parameter int MaxHeight = bme_pkg::MaxHeightDef
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire bme_pkg::t_in_item           i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output bme_pkg::t_out_item               o_out_item,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [bme_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [bme_pkg::MaskW-1:0]   i_cfg_data
);

    localparam int AddrW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
    localparam int ColW  = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;

    bme_pkg::t_cfg        cfg;
    logic                 rd_en;
    logic [AddrW-1:0]     rd_row;
    logic [MaxWidth-1:0]  rd_data;
    logic                 wr_en;
    logic [AddrW-1:0]     wr_row;
    logic [MaxWidth-1:0]  wr_data;

    // Configuration registers.
    bme_cfg_regs #(
        .MaxWidth  (MaxWidth),
        .MaxHeight (MaxHeight)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Binary image storage.
    bme_image_mem #(
        .MaxWidth  (MaxWidth),
        .MaxHeight (MaxHeight),
        .AddrW     (AddrW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_row  (rd_row),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_row  (wr_row),
        .i_wr_data (wr_data)
    );

    // Load and query sequencing.
    bme_query_ctrl #(
        .MaxWidth  (MaxWidth),
        .AddrW     (AddrW),
        .ColW      (ColW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_rd_en     (rd_en),
        .o_rd_row    (rd_row),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_row    (wr_row),
        .o_wr_data   (wr_data)
    );

endmodule

`default_nettype wire

// ----- src/bme_cfg_regs.sv -----
// Configuration register file of the binary morphology engine.
// Depends on bme_pkg for register indexes and the t_cfg type.
`default_nettype none

module bme_cfg_regs #(
    parameter int MaxWidth  = bme_pkg::MaxWidthDef,
    parameter int MaxHeight = bme_pkg::MaxHeightDef
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [bme_pkg::CfgIdxW-1:0]  i_index,
    input  wire logic [bme_pkg::MaskW-1:0]    i_data,
    output bme_pkg::t_cfg                     o_cfg
);

    localparam int WLim = (MaxWidth > bme_pkg::SizeMax) ? bme_pkg::SizeMax : MaxWidth;
    localparam int HLim = (MaxHeight > bme_pkg::SizeMax) ? bme_pkg::SizeMax : MaxHeight;
    localparam logic [bme_pkg::SizeW-1:0] WLimV = bme_pkg::SizeW'(WLim);
    localparam logic [bme_pkg::SizeW-1:0] HLimV = bme_pkg::SizeW'(HLim);
    localparam logic [bme_pkg::ElemW-1:0] ELimV = bme_pkg::ElemW'(bme_pkg::MaxElement);

    logic                         r_mode;
    logic [bme_pkg::SizeW-1:0]    r_img_w;
    logic [bme_pkg::SizeW-1:0]    r_img_h;
    logic [bme_pkg::ElemW-1:0]    r_elem_w;
    logic [bme_pkg::ElemW-1:0]    r_elem_h;
    logic [bme_pkg::MaskW-1:0]    r_mask;

    // Writes are taken in any cycle.
    assign o_ready = 1'b1;

    // Register writes; an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= bme_pkg::ModeDilate;
            r_img_w  <= 9'd256;
            r_img_h  <= 9'd256;
            r_elem_w <= 3'd3;
            r_elem_h <= 3'd3;
            r_mask   <= 49'd511;
        end else if (i_valid) begin
            case (i_index)
                bme_pkg::CfgMode:     r_mode   <= i_data[0];
                bme_pkg::CfgImgW:     r_img_w  <= i_data[bme_pkg::SizeW-1:0];
                bme_pkg::CfgImgH:     r_img_h  <= i_data[bme_pkg::SizeW-1:0];
                bme_pkg::CfgElemW:    r_elem_w <= i_data[bme_pkg::ElemW-1:0];
                bme_pkg::CfgElemH:    r_elem_h <= i_data[bme_pkg::ElemW-1:0];
                bme_pkg::CfgElemMask: r_mask   <= i_data;
                default: ;
            endcase
        end
    end

    // Clamp sizes to what the memory and the element window hold.
    always_comb begin
        o_cfg.mode   = r_mode;
        o_cfg.img_w  = (r_img_w > WLimV) ? WLimV : r_img_w;
        o_cfg.img_h  = (r_img_h > HLimV) ? HLimV : r_img_h;
        o_cfg.elem_w = (r_elem_w > ELimV) ? ELimV : r_elem_w;
        o_cfg.elem_h = (r_elem_h > ELimV) ? ELimV : r_elem_h;
        o_cfg.mask   = r_mask;
    end

endmodule

`default_nettype wire

// ----- src/bme_image_mem.sv -----
// Binary image memory: one word per image row, one read and one write port.
// Read data is registered; depends on nothing but its parameters.
`default_nettype none

module bme_image_mem #(
    parameter int MaxWidth  = 256,
    parameter int MaxHeight = 256,
    parameter int AddrW     = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rd_en,
    input  wire logic [AddrW-1:0]     i_rd_row,
    output logic [MaxWidth-1:0]       o_rd_data,
    input  wire logic                 i_wr_en,
    input  wire logic [AddrW-1:0]     i_wr_row,
    input  wire logic [MaxWidth-1:0]  i_wr_data
);

    logic [MaxWidth-1:0] r_mem [MaxHeight];
    logic [MaxWidth-1:0] r_rd_data;

    // Synchronous read and write of whole rows.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- src/bme_query_ctrl.sv -----
// Sequencer of the morphology engine: pixel loads as row read-modify-write,
// queries as one row read per element row, plus the result register.
// Depends on bme_pkg for item types, the configuration struct and codes.
`default_nettype none

module bme_query_ctrl #(
    parameter int MaxWidth  = 256,
    parameter int AddrW     = 8,
    parameter int ColW      = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bme_pkg::t_cfg        i_cfg,
    input  wire logic                 i_in_valid,
    input  wire bme_pkg::t_in_item    i_in_item,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output bme_pkg::t_out_item        o_out_item,
    output logic                      o_rd_en,
    output logic [AddrW-1:0]          o_rd_row,
    input  wire logic [MaxWidth-1:0]  i_rd_data,
    output logic                      o_wr_en,
    output logic [AddrW-1:0]          o_wr_row,
    output logic [MaxWidth-1:0]       o_wr_data
);

    bme_pkg::t_state                r_state, n_state;
    bme_pkg::t_in_item              r_item, n_item;
    logic [bme_pkg::ElemW-1:0]      r_si, n_si;
    logic                           r_acc, n_acc;
    logic                           r_oor, n_oor;
    logic [AddrW-1:0]               r_rd_row, n_rd_row;
    logic                           r_p_valid, n_p_valid;
    logic [bme_pkg::ElemW-1:0]      r_p_si, n_p_si;
    logic                           r_p_row_ok, n_p_row_ok;
    logic                           r_out_valid, n_out_valid;
    bme_pkg::t_out_item             r_out_item, n_out_item;

    logic                           erode;
    logic                           in_img;
    bme_pkg::t_coord                w_s, h_s;
    bme_pkg::t_coord                ch, cw;
    bme_pkg::t_coord                nr;
    logic                           nr_ok;
    logic [bme_pkg::MaskStride-1:0] mask_row;
    logic                           fail, hit;

    assign erode = (i_cfg.mode == bme_pkg::ModeErode);
    assign w_s   = bme_pkg::t_coord'({1'b0, i_cfg.img_w});
    assign h_s   = bme_pkg::t_coord'({1'b0, i_cfg.img_h});
    assign ch    = bme_pkg::t_coord'(i_cfg.elem_h >> 1);
    assign cw    = bme_pkg::t_coord'(i_cfg.elem_w >> 1);

    // Bounds check of the incoming item.
    assign in_img = ({1'b0, i_in_item.row} < i_cfg.img_h)
                 && ({1'b0, i_in_item.col} < i_cfg.img_w);

    // Image row under the current element row.
    always_comb begin
        if (erode) begin
            nr = bme_pkg::t_coord'(r_item.row) + bme_pkg::t_coord'(r_si) - ch;
        end else begin
            nr = bme_pkg::t_coord'(r_item.row) - bme_pkg::t_coord'(r_si) + ch;
        end
        nr_ok = !nr[bme_pkg::CoordW-1] && (nr < h_s);
    end

    // Evaluate one row word against one row of the element.
    always_comb begin
        bme_pkg::t_coord nc;
        logic            col_ok;
        logic            pix;
        logic            active;
        mask_row = i_cfg.mask[r_p_si * bme_pkg::MaskStride +: bme_pkg::MaskStride];
        fail = 1'b0;
        hit  = 1'b0;
        for (int j = 0; j < bme_pkg::MaxElement; j++) begin
            if (erode) begin
                nc = bme_pkg::t_coord'(r_item.col) + bme_pkg::t_coord'(j) - cw;
            end else begin
                nc = bme_pkg::t_coord'(r_item.col) - bme_pkg::t_coord'(j) + cw;
            end
            col_ok = !nc[bme_pkg::CoordW-1] && (nc < w_s);
            pix    = r_p_row_ok && col_ok && i_rd_data[ColW'($unsigned(nc))];
            active = mask_row[j] && (bme_pkg::ElemW'(j) < i_cfg.elem_w);
            if (active && !pix) begin
                fail = 1'b1;
            end
            if (active && pix) begin
                hit = 1'b1;
            end
        end
    end

    // Next state, memory requests and result register.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_si        = r_si;
        n_acc       = r_acc;
        n_oor       = r_oor;
        n_rd_row    = r_rd_row;
        n_p_valid   = 1'b0;
        n_p_si      = r_p_si;
        n_p_row_ok  = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        o_rd_en     = 1'b0;
        o_rd_row    = AddrW'(i_in_item.row);
        o_wr_en     = 1'b0;
        o_wr_row    = r_rd_row;
        o_wr_data   = i_rd_data;
        o_wr_data[ColW'(r_item.col)] = (r_item.grey >= bme_pkg::GreyThreshold);

        case (r_state)
            bme_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    n_oor  = !in_img;
                    n_acc  = erode;
                    n_si   = '0;
                    if (i_in_item.opcode == bme_pkg::OpLoad) begin
                        if (in_img) begin
                            o_rd_en  = 1'b1;
                            n_rd_row = AddrW'(i_in_item.row);
                            n_state  = bme_pkg::S_LOAD_WR;
                        end
                    end else if (!in_img || (i_cfg.elem_h == '0)) begin
                        n_state = bme_pkg::S_DONE;
                    end else begin
                        n_state = bme_pkg::S_ISSUE;
                    end
                end
            end
            bme_pkg::S_LOAD_WR: begin
                o_wr_en = 1'b1;
                n_state = bme_pkg::S_IDLE;
            end
            bme_pkg::S_ISSUE: begin
                o_rd_en    = nr_ok;
                o_rd_row   = AddrW'($unsigned(nr));
                n_p_valid  = 1'b1;
                n_p_si     = r_si;
                n_p_row_ok = nr_ok;
                n_si       = r_si + 1'b1;
                if (r_si == i_cfg.elem_h - 1'b1) begin
                    n_state = bme_pkg::S_DRAIN;
                end
            end
            bme_pkg::S_DRAIN: begin
                n_state = bme_pkg::S_DONE;
            end
            bme_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_item.out_row      = r_item.row;
                    n_out_item.out_col      = r_item.col;
                    n_out_item.out_value    = (!r_oor && r_acc) ? bme_pkg::White
                                                                : bme_pkg::Black;
                    n_out_item.out_of_range = r_oor;
                    n_state                 = bme_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bme_pkg::S_IDLE;
            end
        endcase

        // Fold the row just read into the running result.
        if (r_p_valid) begin
            n_acc = erode ? (r_acc && !fail) : (r_acc || hit);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bme_pkg::S_IDLE;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_si       <= n_si;
        r_acc      <= n_acc;
        r_oor      <= n_oor;
        r_rd_row   <= n_rd_row;
        r_p_si     <= n_p_si;
        r_p_row_ok <= n_p_row_ok;
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = (r_state != bme_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- tb/tb_binary_morphology_engine_top.sv -----
// Self-checking testbench for the binary morphology engine top level.
// Predicts every query result of dilation and erosion and compares it with the
// block's output; depends on bme_pkg and binary_morphology_engine_top.
module tb_binary_morphology_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bme_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REACH         = MaxElement / 2;
    localparam int MAX_REPORTS   = 10;

    // Clock, reset and block ports.
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    t_in_item             in_item    = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index  = CfgMode;
    logic [MaskW-1:0]     cfg_data   = '0;

    // Engine settings as last written, reset values included.
    logic                 eng_mode   = ModeDilate;
    logic [SizeW-1:0]     eng_img_w  = 9'd256;
    logic [SizeW-1:0]     eng_img_h  = 9'd256;
    logic [ElemW-1:0]     eng_elem_w = 3'd3;
    logic [ElemW-1:0]     eng_elem_h = 3'd3;
    logic [MaskW-1:0]     eng_mask   = 49'h1FF;

    // Binary image as the engine should hold it, and which pixels were loaded.
    bit image_bits   [MaxHeightDef][MaxWidthDef];
    bit pixel_loaded [MaxHeightDef][MaxWidthDef];

    t_in_item  pixel_requests [$];
    t_out_item expected_pixels [$];
    t_out_item want;

    int  mismatch_count = 0;
    int  requests_sent  = 0;
    int  cycle_count    = 0;
    int  density_pct    = 50;
    bit  no_idle        = 1'b0;

    binary_morphology_engine_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Effective image size, clamped to the memory size.
    function automatic int img_rows();
        return (eng_img_h > MaxHeightDef) ? MaxHeightDef : int'(eng_img_h);
    endfunction

    function automatic int img_cols();
        return (eng_img_w > MaxWidthDef) ? MaxWidthDef : int'(eng_img_w);
    endfunction

    function automatic bit stored_one(int r, int c);
        if (r < 0 || c < 0 || r >= img_rows() || c >= img_cols()) return 1'b0;
        return image_bits[r][c];
    endfunction

    // Result pixel at (r, c): dilation reflects the element about its centre,
    // erosion needs every active cell to lie inside the image on a set pixel.
    function automatic bit morph_result(int r, int c);
        int si, sj, ch, cw;
        bit hit, covered;
        ch = eng_elem_h / 2;
        cw = eng_elem_w / 2;
        hit = 1'b0;
        covered = 1'b1;
        for (si = 0; si < eng_elem_h; si++) begin
            for (sj = 0; sj < eng_elem_w; sj++) begin
                if (eng_mask[si * MaskStride + sj]) begin
                    if (eng_mode == ModeErode) begin
                        if (!stored_one(r + si - ch, c + sj - cw)) covered = 1'b0;
                    end else if (stored_one(r - si + ch, c - sj + cw)) begin
                        hit = 1'b1;
                    end
                end
            end
        end
        return (eng_mode == ModeErode) ? covered : hit;
    endfunction

    // Applies one accepted load to the image, or queues the result of a query.
    function automatic void predict_request(t_in_item req);
        t_out_item res;
        bit in_img;
        in_img = (req.row < img_rows()) && (req.col < img_cols());
        if (req.opcode == OpLoad) begin
            if (in_img) image_bits[req.row][req.col] = (req.grey >= GreyThreshold);
        end else begin
            res.out_row      = req.row;
            res.out_col      = req.col;
            res.out_of_range = !in_img;
            res.out_value    = (in_img && morph_result(int'(req.row), int'(req.col)))
                               ? White : Black;
            expected_pixels.push_back(res);
        end
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 11);
    endfunction

    function automatic logic [PixW-1:0] grey_sample();
        if ($urandom_range(99) < density_pct) return PixW'($urandom_range(255, 128));
        return PixW'($urandom_range(127, 0));
    endfunction

    function automatic logic [MaskW-1:0] random_mask();
        logic [63:0] a, b;
        logic [MaskW-1:0] one;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        one = '0;
        case ($urandom_range(3))
            0: return '1;
            1: return a[MaskW-1:0];
            2: return a[MaskW-1:0] & b[MaskW-1:0];
            default: begin
                one[$urandom_range(MaskW - 1)] = 1'b1;
                return one;
            end
        endcase
    endfunction

    // Input driver: a new transfer is presented only once the previous one
    // is taken, and predicted at the edge that accepts it.
    always @(posedge clk) begin
        if (in_valid && in_stall == 1'b0) predict_request(in_item);
        if (!in_valid || in_stall == 1'b0) begin
            if (pixel_requests.size() != 0 && !idle_now()) begin
                in_valid <= 1'b1;
                in_item  <= pixel_requests.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result checker and output stall generator.
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: row %0d col %0d value %0d oor %0b",
                             out_item.out_row, out_item.out_col, out_item.out_value,
                             out_item.out_of_range);
            end else begin
                want = expected_pixels.pop_front();
                if (out_item.out_row !== want.out_row || out_item.out_col !== want.out_col
                    || out_item.out_value !== want.out_value
                    || out_item.out_of_range !== want.out_of_range) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: want r%0d c%0d v%0d o%0b got r%0d c%0d v%0d o%0b",
                                 want.out_row, want.out_col, want.out_value,
                                 want.out_of_range, out_item.out_row, out_item.out_col,
                                 out_item.out_value, out_item.out_of_range);
                end
            end
        end
        out_stall <= idle_now();
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Queues one transfer and returns once the driver has picked it up.
    task automatic send_item(input logic op, input int r, input int c,
                             input logic [PixW-1:0] g);
        t_in_item req;
        req.opcode = op;
        req.row    = r[PixW-1:0];
        req.col    = c[PixW-1:0];
        req.grey   = g;
        if (op == OpLoad && r < img_rows() && c < img_cols()) pixel_loaded[r][c] = 1'b1;
        pixel_requests.push_back(req);
        requests_sent++;
        while (pixel_requests.size() != 0) @(posedge clk);
    endtask

    // Waits until nothing is in flight, loads included.
    task automatic wait_idle();
        while (pixel_requests.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all six registers back to back once the engine is idle.
    task automatic program_engine(input logic mode, input int iw, input int ih,
                                  input int ew, input int eh, input logic [MaskW-1:0] mask);
        logic [CfgIdxW-1:0] idx;
        logic [MaskW-1:0] val;
        int k;
        wait_idle();
        cfg_valid <= 1'b1;
        for (k = 0; k < 6; k++) begin
            val = '0;
            case (k)
                0: begin idx = CfgMode;     val[0] = mode;               end
                1: begin idx = CfgImgW;     val[SizeW-1:0] = iw[SizeW-1:0]; end
                2: begin idx = CfgImgH;     val[SizeW-1:0] = ih[SizeW-1:0]; end
                3: begin idx = CfgElemW;    val[ElemW-1:0] = ew[ElemW-1:0]; end
                4: begin idx = CfgElemH;    val[ElemW-1:0] = eh[ElemW-1:0]; end
                default: begin idx = CfgElemMask; val = mask;          end
            endcase
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge clk); while (cfg_ready !== 1'b1);
            case (idx)
                CfgMode:  eng_mode   = val[0];
                CfgImgW:  eng_img_w  = val[SizeW-1:0];
                CfgImgH:  eng_img_h  = val[SizeW-1:0];
                CfgElemW: eng_elem_w = val[ElemW-1:0];
                CfgElemH: eng_elem_h = val[ElemW-1:0];
                default:  eng_mask   = val;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Query at (r, c), first loading any pixel the element could reach.
    task automatic query_at(input int r, input int c);
        int dr, dc;
        for (dr = -REACH; dr <= REACH; dr++) begin
            for (dc = -REACH; dc <= REACH; dc++) begin
                if (r + dr >= 0 && c + dc >= 0 && r + dr < img_rows() && c + dc < img_cols()
                    && !pixel_loaded[r + dr][c + dc])
                    send_item(OpLoad, r + dr, c + dc, grey_sample());
            end
        end
        send_item(OpQuery, r, c, PixW'($urandom_range(255)));
    endtask

    // Picks a position outside the current image when it can; it may stay inside if only the rows leave room.
    task automatic pick_outside(output int r, output int c);
        r = $urandom_range(255);
        c = $urandom_range(255);
        if (r < img_rows() && c < img_cols()) begin
            if ($urandom_range(1) && img_rows() < MaxHeightDef) r = $urandom_range(255, img_rows());
            else if (img_cols() < MaxWidthDef) c = $urandom_range(255, img_cols());
        end
    endtask

    // Hand-picked cases, mostly on a 3x3 image: grey values around the threshold,
    // both modes, edges, empty elements and clamped or zero image sizes.
    task automatic test_directed();
        program_engine(ModeDilate, 3, 3, 3, 3, 49'h1FF);
        send_item(OpLoad, 0, 0, 8'd255);
        send_item(OpLoad, 0, 1, 8'd0);
        send_item(OpLoad, 0, 2, 8'd128);
        send_item(OpLoad, 1, 0, 8'd127);
        send_item(OpLoad, 1, 1, 8'd200);
        send_item(OpLoad, 1, 2, 8'd0);
        send_item(OpLoad, 2, 0, 8'd0);
        send_item(OpLoad, 2, 1, 8'd128);
        send_item(OpLoad, 2, 2, 8'd255);
        send_item(OpQuery, 0, 0, 8'd0);
        send_item(OpQuery, 2, 2, 8'd255);
        send_item(OpQuery, 3, 0, 8'd0);
        send_item(OpQuery, 255, 255, 8'd0);
        // A load outside the image must leave the image alone.
        send_item(OpLoad, 255, 255, 8'd255);
        send_item(OpQuery, 1, 1, 8'd0);

        program_engine(ModeErode, 3, 3, 3, 3, 49'h1FF);
        send_item(OpQuery, 1, 1, 8'd0);

        // Single-cell element; mask bits beyond the element are ignored.
        program_engine(ModeErode, 3, 3, 1, 1, 49'h1_0000_0000_0101);
        send_item(OpQuery, 0, 0, 8'd0);
        send_item(OpQuery, 0, 1, 8'd0);

        // Dilation without the centre cell does not keep the stored pixel.
        program_engine(ModeDilate, 3, 3, 2, 2, 49'h1);
        send_item(OpQuery, 2, 2, 8'd0);
        send_item(OpQuery, 1, 1, 8'd0);

        // No active cell: dilation gives black, erosion white.
        program_engine(ModeDilate, 3, 3, 0, 0, 49'h1FF);
        send_item(OpQuery, 0, 0, 8'd0);
        program_engine(ModeErode, 3, 3, 3, 3, 49'h0);
        send_item(OpQuery, 1, 1, 8'd0);

        // Zero width ignores loads; oversized registers clamp to the memory.
        program_engine(ModeDilate, 0, 3, 1, 1, 49'h1);
        send_item(OpLoad, 0, 0, 8'd0);
        send_item(OpQuery, 0, 0, 8'd0);
        program_engine(ModeDilate, 511, 300, 1, 1, 49'h1);
        send_item(OpLoad, 255, 255, 8'd255);
        send_item(OpQuery, 255, 255, 8'd0);
        send_item(OpQuery, 0, 0, 8'd0);
    endtask

    // Many short phases on small images with random elements and densities.
    task automatic test_small_images();
        int r, c, sel, iw, ih;
        while (requests_sent < 900) begin
            case ($urandom_range(15))
                0: iw = 0;
                1: iw = $urandom_range(40, 13);
                default: iw = $urandom_range(12, 1);
            endcase
            case ($urandom_range(15))
                0: ih = 0;
                1: ih = $urandom_range(40, 13);
                default: ih = $urandom_range(12, 1);
            endcase
            case ($urandom_range(3))
                0: density_pct = 10;
                1: density_pct = 50;
                2: density_pct = 85;
                default: density_pct = 97;
            endcase
            program_engine(1'($urandom_range(1)), iw, ih, $urandom_range(7),
                           $urandom_range(7), random_mask());
            repeat ($urandom_range(50, 20)) begin
                sel = $urandom_range(99);
                if (img_rows() == 0 || img_cols() == 0 || sel >= 88) begin
                    // Noise: transfers outside the image.
                    pick_outside(r, c);
                    send_item(sel[0] ? OpQuery : OpLoad, r, c, PixW'($urandom_range(255)));
                end else if (sel < 72) begin
                    query_at($urandom_range(img_rows() - 1), $urandom_range(img_cols() - 1));
                end else begin
                    send_item(OpLoad, $urandom_range(img_rows() - 1),
                              $urandom_range(img_cols() - 1), grey_sample());
                end
            end
        end
    endtask

    // Full-size and clamped images, queried in clusters near the corners and at one random spot.
    task automatic test_large_image();
        int p, ar, ac, iw, ih, r, c;
        density_pct = 92;
        for (p = 0; p < 5; p++) begin
            case (p)
                0: begin ar = 0;   ac = 0;   iw = 256; ih = 256; end
                1: begin ar = 0;   ac = 255; iw = 511; ih = 300; end
                2: begin ar = 255; ac = 0;   iw = 300; ih = 256; end
                3: begin ar = 255; ac = 255; iw = 256; ih = 511; end
                default: begin
                    ar = $urandom_range(250, 100);
                    ac = $urandom_range(250, 100);
                    iw = 256;
                    ih = 256;
                end
            endcase
            program_engine(p[0] ? ModeErode : ModeDilate, iw, ih, $urandom_range(7, 1),
                           $urandom_range(7, 1), random_mask());
            repeat (30) begin
                r = ar + int'($urandom_range(4)) - 2;
                c = ac + int'($urandom_range(4)) - 2;
                if (r < 0) r = 0;
                if (r > 255) r = 255;
                if (c < 0) c = 0;
                if (c > 255) c = 255;
                query_at(r, c);
            end
        end
    endtask

    // Back-to-back transfers with neither side idling.
    task automatic test_steady_stream();
        density_pct = 70;
        no_idle = 1'b1;
        program_engine(1'($urandom_range(1)), 6, 6, 3, 3, random_mask());
        repeat (150) begin
            if ($urandom_range(99) < 85)
                query_at($urandom_range(5), $urandom_range(5));
            else
                send_item(OpLoad, $urandom_range(5), $urandom_range(5), grey_sample());
        end
        wait_idle();
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_small_images();
        test_large_image();
        test_steady_stream();
        wait_idle();
        if (mismatch_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
src/bme_pkg.sv
src/bme_cfg_regs.sv
src/bme_image_mem.sv
src/bme_query_ctrl.sv
src/binary_morphology_engine_top.sv
tb/tb_binary_morphology_engine_top.sv
